// ----- hdl/text_mode_terminal_writer_unit_assert.svh -----
// Assertion macros for the text-mode terminal writer checker.
// Depends on nothing; included by the checker file only.
`ifndef TEXT_MODE_TERMINAL_WRITER_UNIT_ASSERT_SVH
`define TEXT_MODE_TERMINAL_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define TMTW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tmtw assertion failed");

// Next-cycle implication, switched off while reset is high.
`define TMTW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tmtw assertion failed");

`endif

// ----- hdl/tmtw_pkg.sv -----
// Shared types and constants of the text-mode terminal writer.
// Depends on nothing; used by the interfaces and every module.
package tmtw_pkg;

  localparam int REQ_TYPE_W   = 2;
  localparam int CHAR_W       = 8;
  localparam int CELL_INDEX_W = 11;
  localparam int CURSOR_COL_W = 7;
  localparam int CURSOR_ROW_W = 5;
  localparam int CELL_W       = 16;
  localparam int COLOR_W      = 8;

  localparam logic [REQ_TYPE_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // capture the request and start the port-side read
    logic exec;       // apply the captured request to cursor and store
    logic sweep_clr;  // restart the sweep counter
    logic sweep_inc;  // advance the sweep counter
    logic blank_wr;   // write a blank cell at the sweep address
    logic reset_color;// blank with the reset colour instead of the register
    logic copy_en;    // one step of the scroll copy
    logic load_out;   // load the result register
  } tmtw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic                  put_scroll;
    logic                  sweep_last;
    logic                  copy_done;
    logic                  out_free;
  } tmtw_status_t;

endpackage

// ----- hdl/tmtw_if.sv -----
// Request and result channel interfaces of the text-mode terminal writer.
// Depends on tmtw_pkg for the field widths.
interface tmtw_req_if;
  import tmtw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [REQ_TYPE_W-1:0]   req_type;
  logic [CHAR_W-1:0]       char_code;
  logic [CELL_INDEX_W-1:0] cell_index;

  modport source (output valid, req_type, char_code, cell_index, input ready);
  modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tmtw_rsp_if;
  import tmtw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CURSOR_COL_W-1:0] cursor_col;
  logic [CURSOR_ROW_W-1:0] cursor_row;
  logic [CELL_W-1:0]       cell_data;
  logic                    scrolled;

  modport source (output valid, cursor_col, cursor_row, cell_data, scrolled,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_data, scrolled,
                  output ready);
endinterface

// ----- hdl/tmtw_datapath.sv -----
// Datapath: screen store, cursor, colour register, sweep counter, result register.
// Depends on tmtw_pkg; driven by tmtw_controller through command signals.
module tmtw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tmtw_pkg::tmtw_cmd_t                cmd,
  output tmtw_pkg::tmtw_status_t             status,
  input  logic                               cfg_wr_en,
  input  logic [tmtw_pkg::COLOR_W-1:0]       cfg_wr_data,
  input  logic [tmtw_pkg::REQ_TYPE_W-1:0]    req_type,
  input  logic [tmtw_pkg::CHAR_W-1:0]        char_code,
  input  logic [tmtw_pkg::CELL_INDEX_W-1:0]  cell_index,
  input  logic                               rsp_ready,
  output logic                               rsp_valid,
  output logic [tmtw_pkg::CURSOR_COL_W-1:0]  cursor_col,
  output logic [tmtw_pkg::CURSOR_ROW_W-1:0]  cursor_row,
  output logic [tmtw_pkg::CELL_W-1:0]        cell_data,
  output logic                               scrolled
);
  import tmtw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CMP_W  = (ADDR_W + 1 > CELL_INDEX_W) ? ADDR_W + 1 : CELL_INDEX_W + 1;
  localparam int COL_X  = (COL_W > CURSOR_COL_W) ? COL_W : CURSOR_COL_W;
  localparam int ROW_X  = (ROW_W > CURSOR_ROW_W) ? ROW_W : CURSOR_ROW_W;
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

  logic [CELL_W-1:0]     mem [CELLS];
  logic [CELL_W-1:0]     rdata;
  logic [COLOR_W-1:0]    text_color;
  logic [REQ_TYPE_W-1:0] req_type_q;
  logic [CHAR_W-1:0]     char_q;
  logic                  in_range;
  logic [COL_W-1:0]      cur_col, cur_col_next;
  logic [ROW_W-1:0]      cur_row, cur_row_next;
  logic                  did_scroll, did_scroll_next;
  logic [ADDR_W-1:0]     sweep;

  logic [CMP_W-1:0]      idx_x;
  logic                  is_nl, is_cr, is_bs, is_print;
  logic                  col_last, row_last, adv_row;
  logic                  put_wr;
  logic [COL_W-1:0]      wr_col;
  logic [ADDR_W-1:0]     put_addr;
  logic                  wr_en, rd_en;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  logic [CELL_W-1:0]     wr_data;
  logic [COLOR_W-1:0]    blank_color;
  logic [COL_X-1:0]      col_x;
  logic [ROW_X-1:0]      row_x;

  assign idx_x = CMP_W'(cell_index);

  // Decode of the captured put request.
  assign is_nl    = (char_q == CH_NEWLINE);
  assign is_cr    = (char_q == CH_RETURN);
  assign is_bs    = (char_q == CH_BACKSPACE);
  assign is_print = !is_nl && !is_cr && !is_bs;
  assign col_last = (cur_col == LAST_COL);
  assign row_last = (cur_row == LAST_ROW);
  assign adv_row  = is_nl || (is_print && col_last);
  assign put_wr   = is_print || (is_bs && (cur_col != '0));
  assign wr_col   = is_bs ? cur_col - COL_W'(1) : cur_col;
  assign put_addr = ADDR_W'(cur_row) * COLS_A + ADDR_W'(wr_col);

  always_comb begin
    cur_col_next    = cur_col;
    cur_row_next    = cur_row;
    did_scroll_next = did_scroll;
    if (cmd.exec) begin
      did_scroll_next = 1'b0;
      case (req_type_q)
        REQ_PUT: begin
          if (is_nl || is_cr) begin
            cur_col_next = '0;
          end else if (is_bs) begin
            // Backspace at column zero leaves the cursor where it is.
            if (cur_col != '0) begin
              cur_col_next = wr_col;
            end
          end else begin
            cur_col_next = col_last ? '0 : cur_col + COL_W'(1);
          end
          if (adv_row && !row_last) begin
            cur_row_next = cur_row + ROW_W'(1);
          end
          did_scroll_next = adv_row && row_last;
        end
        REQ_CLEAR: begin
          cur_col_next = '0;
          cur_row_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Store write and read port selection.
  assign blank_color = cmd.reset_color ? RESET_COLOR : text_color;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = put_addr;
    wr_data = {text_color, (is_bs ? CH_SPACE : char_q)};
    if (cmd.exec && (req_type_q == REQ_PUT) && put_wr) begin
      wr_en = 1'b1;
    end else if (cmd.blank_wr) begin
      wr_en   = 1'b1;
      wr_addr = sweep;
      wr_data = {blank_color, CH_SPACE};
    end else if (cmd.copy_en && (sweep != '0)) begin
      wr_en   = 1'b1;
      wr_addr = sweep - ADDR_W'(1);
      wr_data = rdata;
    end
  end

  assign rd_en   = cmd.accept || (cmd.copy_en && (sweep != COPY_END));
  assign rd_addr = cmd.copy_en ? sweep + COLS_A : idx_x[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
      cur_col    <= '0;
      cur_row    <= '0;
      did_scroll <= 1'b0;
      sweep      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        text_color <= cfg_wr_data;
      end
      cur_col    <= cur_col_next;
      cur_row    <= cur_row_next;
      did_scroll <= did_scroll_next;
      if (cmd.sweep_clr) begin
        sweep <= '0;
      end else if (cmd.sweep_inc) begin
        sweep <= sweep + ADDR_W'(1);
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign col_x = COL_X'(cur_col_next);
  assign row_x = ROW_X'(cur_row_next);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type_q <= req_type;
      char_q     <= char_code;
      in_range   <= (idx_x < CMP_W'(CELLS));
    end
    if (cmd.load_out) begin
      cursor_col <= col_x[CURSOR_COL_W-1:0];
      cursor_row <= row_x[CURSOR_ROW_W-1:0];
      cell_data  <= ((req_type_q == REQ_READ) && in_range) ? rdata : '0;
      scrolled   <= did_scroll_next;
    end
  end

  assign status.req_type   = req_type_q;
  assign status.put_scroll = adv_row && row_last;
  assign status.sweep_last = (sweep == LAST_CELL);
  assign status.copy_done  = (sweep == COPY_END);
  assign status.out_free   = !rsp_valid || rsp_ready;

endmodule

// ----- hdl/tmtw_controller.sv -----
// Controller state machine: sequences request execution, sweeps and result hand-off.
// Depends on tmtw_pkg; drives tmtw_datapath through command signals.
module tmtw_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tmtw_pkg::tmtw_status_t status,
  output tmtw_pkg::tmtw_cmd_t    cmd
);
  import tmtw_pkg::*;

  localparam logic [2:0] ST_RESET_CLR = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_EXEC      = 3'd2;
  localparam logic [2:0] ST_COPY      = 3'd3;
  localparam logic [2:0] ST_BLANK     = 3'd4;
  localparam logic [2:0] ST_CLEAR     = 3'd5;
  localparam logic [2:0] ST_RESP      = 3'd6;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_RESET_CLR: begin
        cmd.blank_wr    = 1'b1;
        cmd.reset_color = 1'b1;
        cmd.sweep_inc   = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if ((status.req_type == REQ_PUT) && status.put_scroll) begin
          cmd.sweep_clr = 1'b1;
          state_next    = ST_COPY;
        end else if (status.req_type == REQ_CLEAR) begin
          cmd.sweep_clr = 1'b1;
          state_next    = ST_CLEAR;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_COPY: begin
        cmd.copy_en = 1'b1;
        if (status.copy_done) begin
          state_next = ST_BLANK;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      ST_BLANK, ST_CLEAR: begin
        cmd.blank_wr  = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RESET_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/text_mode_terminal_writer_unit.sv -----
// Top level of the text-mode terminal writer: character-cell screen store and cursor.
// Depends on tmtw_pkg, tmtw_if, tmtw_controller and tmtw_datapath.
//
// Usage. Requests arrive on the req channel (put character, clear screen, read one
// cell) and every request gives exactly one result on the rsp channel: the cursor
// position after the request, the cell word for a read (zero otherwise) and a flag
// that is set when the request scrolled the screen. A transfer takes place on a
// clock edge with valid and ready both high. The colour attribute is written through
// cfg_wr_en and cfg_wr_data and colours every character and blank written afterwards.
//
// Timing. The block works on one request at a time. A put that does not scroll, a
// read and an unused request type pass through the execute state and load their
// result straight into the output register if it is free, else wait in the result
// state. A clear walks the whole store one cell a cycle; a put that scrolls copies
// every line up and blanks the bottom line. The single write port of the screen
// store sets the pace of these passes.
//
// Reset. After rst the store is blanked by a clearing pass over all ROWS*COLUMNS cells
// (2000 at the default size) during which req.ready stays low; colour writes are
// taken throughout. When the receiver stalls, the result is held in its output
// register and the next request is still taken; its result waits until that
// register frees up.
module text_mode_terminal_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                         clk,
  input  logic                         rst,
  tmtw_req_if.sink                     req,
  tmtw_rsp_if.source                   rsp,
  input  logic                         cfg_wr_en,
  input  logic [tmtw_pkg::COLOR_W-1:0] cfg_wr_data
);
  import tmtw_pkg::*;

  tmtw_cmd_t    cmd;
  tmtw_status_t status;
  logic         in_ready;

  assign req.ready = in_ready;

  // The controller decides what happens in each cycle; it sees only req.valid and status.
  tmtw_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the store, the cursor and the result register.
  tmtw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_type    (req.req_type),
    .char_code   (req.char_code),
    .cell_index  (req.cell_index),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .cursor_col  (rsp.cursor_col),
    .cursor_row  (rsp.cursor_row),
    .cell_data   (rsp.cell_data),
    .scrolled    (rsp.scrolled)
  );

endmodule

// ----- hdl/tmtw_checker.sv -----
// Port-level checker for the text-mode terminal writer, bound to the top level.
// Depends on tmtw_pkg and the macros in text_mode_terminal_writer_unit_assert.svh.
`include "text_mode_terminal_writer_unit_assert.svh"

module tmtw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [tmtw_pkg::CURSOR_COL_W-1:0] rsp_cursor_col,
  input logic [tmtw_pkg::CURSOR_ROW_W-1:0] rsp_cursor_row,
  input logic                              rsp_scrolled
);
  import tmtw_pkg::*;

  logic cursor_on_screen;
  logic cursor_at_bottom_start;

  assign cursor_on_screen = (int'(rsp_cursor_col) < COLUMNS) &&
                            (int'(rsp_cursor_row) < ROWS);
  assign cursor_at_bottom_start = (rsp_cursor_col == '0) &&
                                  (rsp_cursor_row == CURSOR_ROW_W'(ROWS - 1));

  // A reported cursor always lies on the screen.
  `TMTW_ASSERT_IMP(a_cursor_on_screen, clk, rst, rsp_valid, cursor_on_screen)

  // A scroll leaves the cursor at the start of the bottom row.
  `TMTW_ASSERT_IMP(a_scroll_cursor, clk, rst, rsp_valid && rsp_scrolled, cursor_at_bottom_start)

  // Requests are handled one at a time, so ready drops after each transfer.
  `TMTW_ASSERT_NXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready)

  // A stalled result stays offered.
  `TMTW_ASSERT_NXT(a_rsp_valid_holds, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind text_mode_terminal_writer_unit tmtw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tmtw_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_cursor_col (rsp.cursor_col),
  .rsp_cursor_row (rsp.cursor_row),
  .rsp_scrolled   (rsp.scrolled)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for the text-mode terminal writer: directed table, then random traffic.
// Depends on tmtw_pkg, the tmtw_req_if/tmtw_rsp_if interfaces and text_mode_terminal_writer_unit.
// A screen and cursor model inside the testbench predicts every result of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tmtw_pkg::*;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  // The request type that the block must ignore.
  localparam logic [REQ_TYPE_W-1:0] REQ_NONE = 2'd3;

  localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_COLOR, CH_SPACE};

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 250;
  // The phase in which neither side idles, so that the block alone sets the pace of transfers.
  localparam int BURST_PHASE   = 2;
  localparam int SETTLE_CYCLES = 20;

  // Worst case per request: a scroll or a clear, the longest sender gap and the longest
  // receiver stall, over roughly 1650 requests, after the clearing pass that follows
  // reset. The limit is several times that total.
  localparam longint CYCLE_LIMIT = 12_000_000;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0]   req_type;
    logic [CHAR_W-1:0]       char_code;
    logic [CELL_INDEX_W-1:0] cell_index;
  } term_req_t;

  typedef struct packed {
    logic [CURSOR_COL_W-1:0] cursor_col;
    logic [CURSOR_ROW_W-1:0] cursor_row;
    logic [CELL_W-1:0]       cell_data;
    logic                    scrolled;
  } term_result_t;

  // One line of the directed table. Where typed is set, want holds the result written out
  // by hand; otherwise the screen model supplies it.
  typedef struct {
    term_req_t    req;
    int           reps;
    bit           typed;
    term_result_t want;
  } table_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [COLOR_W-1:0] cfg_wr_data;
  logic               result_ready = 1'b0;

  tmtw_req_if req_ch ();
  tmtw_rsp_if rsp_ch ();

  assign rsp_ch.ready = result_ready;

  text_mode_terminal_writer_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Screen model: its own copy of the store, the cursor and the colour attribute.
  logic [CELL_W-1:0]  screen_model [CELL_COUNT];
  int                 model_row;
  int                 model_col;
  logic [COLOR_W-1:0] model_color;

  // Results owed by the block, oldest first.
  term_result_t awaited_results [$];
  table_row_t   stimulus_table [$];
  term_result_t oldest_result;

  bit     idle_on = 1'b1;
  int     stall_left = 0;
  int     mismatches = 0;
  int     requests_sent = 0;
  int     results_seen = 0;
  int     read_count = 0;
  int     clear_count = 0;
  int     scroll_count = 0;
  int     colour_writes = 0;
  longint cycle_count = 0;

  // Applies one request to the screen model and returns what the block should answer.
  function automatic term_result_t terminal_apply(input term_req_t r);
    term_result_t res;
    int           i;
    res = '0;
    case (r.req_type)
      REQ_PUT: begin
        if (r.char_code == CH_NEWLINE) begin
          model_row++;
          model_col = 0;
        end else if (r.char_code == CH_RETURN) begin
          model_col = 0;
        end else if (r.char_code == CH_BACKSPACE) begin
          // Backspace stays within the row; at column zero nothing happens at all.
          if (model_col > 0) begin
            model_col--;
            screen_model[model_row * COLUMNS + model_col] = {model_color, CH_SPACE};
          end
        end else begin
          screen_model[model_row * COLUMNS + model_col] = {model_color, r.char_code};
          model_col++;
        end
        if (model_col >= COLUMNS) begin
          model_row++;
          model_col = 0;
        end
        // Passing the bottom row moves every line up and blanks the last one.
        if (model_row >= ROWS) begin
          for (i = 0; i < CELL_COUNT - COLUMNS; i++) begin
            screen_model[i] = screen_model[i + COLUMNS];
          end
          for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
            screen_model[i] = {model_color, CH_SPACE};
          end
          model_row    = ROWS - 1;
          model_col    = 0;
          res.scrolled = 1'b1;
        end
      end
      REQ_CLEAR: begin
        for (i = 0; i < CELL_COUNT; i++) begin
          screen_model[i] = {model_color, CH_SPACE};
        end
        model_row = 0;
        model_col = 0;
      end
      REQ_READ: begin
        // Indexes past the end of the store read as zero.
        if (r.cell_index < CELL_COUNT) begin
          res.cell_data = screen_model[r.cell_index];
        end
      end
      default: begin
      end
    endcase
    res.cursor_col = CURSOR_COL_W'(model_col);
    res.cursor_row = CURSOR_ROW_W'(model_row);
    return res;
  endfunction

  function automatic void add_row(input logic [REQ_TYPE_W-1:0] kind,
                                  input logic [CHAR_W-1:0] ch,
                                  input logic [CELL_INDEX_W-1:0] idx, input int reps,
                                  input bit typed, input int col, input int row,
                                  input logic [CELL_W-1:0] data, input bit scr);
    table_row_t t;
    t.req            = '{req_type: kind, char_code: ch, cell_index: idx};
    t.reps           = reps;
    t.typed          = typed;
    t.want.cursor_col = CURSOR_COL_W'(col);
    t.want.cursor_row = CURSOR_ROW_W'(row);
    t.want.cell_data  = data;
    t.want.scrolled   = scr;
    stimulus_table.push_back(t);
  endfunction

  // Random requests are mostly puts, so that the cursor wanders over the whole screen, wraps
  // at row ends and scrolls. Half of the reads look at the cursor's row, where the writes land.
  // Clears are kept rare because each one walks the whole store.
  function automatic term_req_t draw_request();
    term_req_t r;
    int        pick;
    int        ch_pick;
    int        idx_pick;
    r.req_type   = REQ_PUT;
    r.char_code  = CHAR_W'($urandom_range(0, 255));
    r.cell_index = CELL_INDEX_W'($urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      r.req_type = REQ_CLEAR;
    end else if (pick < 4) begin
      r.req_type = REQ_NONE;
    end else if (pick < 24) begin
      r.req_type = REQ_READ;
      idx_pick = $urandom_range(0, 9);
      if (idx_pick < 5) begin
        r.cell_index = CELL_INDEX_W'(model_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
      end else if (idx_pick < 8) begin
        r.cell_index = CELL_INDEX_W'($urandom_range(0, CELL_COUNT - 1));
      end else if (idx_pick < 9) begin
        r.cell_index = CELL_INDEX_W'($urandom_range(CELL_COUNT, 2047));
      end
    end else begin
      ch_pick = $urandom_range(0, 99);
      if (ch_pick < 8) begin
        r.char_code = CH_NEWLINE;
      end else if (ch_pick < 11) begin
        r.char_code = CH_RETURN;
      end else if (ch_pick < 19) begin
        r.char_code = CH_BACKSPACE;
      end
    end
    return r;
  endfunction

  // Presents one request, after a random gap while idling is on, and waits for its transfer.
  // The expectation is recorded at the transfer edge, always before the matching result appears.
  task automatic send_request(input term_req_t r, input bit typed, input term_result_t want);
    int           gap;
    term_result_t got;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.req_type;
    req_ch.char_code  <= r.char_code;
    req_ch.cell_index <= r.cell_index;
    do @(posedge clk); while (!req_ch.ready);
    got = terminal_apply(r);
    awaited_results.push_back(typed ? want : got);
    requests_sent++;
    if (r.req_type == REQ_READ) read_count++;
    if (r.req_type == REQ_CLEAR) clear_count++;
    if (got.scrolled) scroll_count++;
  endtask

  // Lowers valid and waits until every owed result has been handed over. Each request gives
  // exactly one result, so the block is idle once the queue is empty.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_text_colour(input logic [COLOR_W-1:0] colour);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= colour;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_color = colour;
    colour_writes++;
  endtask

  // Result side: checks every transfer against the oldest expectation, then draws how long
  // to hold ready low before the next one.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && result_ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatches++;
      end else begin
        oldest_result = awaited_results.pop_front();
        if (rsp_ch.cursor_col !== oldest_result.cursor_col) begin
          $error("cursor_col: expected %0d, actual %0d", oldest_result.cursor_col,
                 rsp_ch.cursor_col);
          mismatches++;
        end
        if (rsp_ch.cursor_row !== oldest_result.cursor_row) begin
          $error("cursor_row: expected %0d, actual %0d", oldest_result.cursor_row,
                 rsp_ch.cursor_row);
          mismatches++;
        end
        if (rsp_ch.cell_data !== oldest_result.cell_data) begin
          $error("cell_data: expected %h, actual %h", oldest_result.cell_data,
                 rsp_ch.cell_data);
          mismatches++;
        end
        if (rsp_ch.scrolled !== oldest_result.scrolled) begin
          $error("scrolled: expected %0b, actual %0b", oldest_result.scrolled,
                 rsp_ch.scrolled);
          mismatches++;
        end
      end
      stall_left = idle_on ? $urandom_range(0, 10) : 0;
    end
    if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int                 ph;
    int                 n;
    int                 k;
    logic [COLOR_W-1:0] colour;

    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= RESET_COLOR;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_PUT;
    req_ch.char_code  <= '0;
    req_ch.cell_index <= '0;

    for (k = 0; k < CELL_COUNT; k++) begin
      screen_model[k] = RESET_BLANK;
    end
    model_row   = 0;
    model_col   = 0;
    model_color = RESET_COLOR;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The clearing pass after reset blanks with the reset colour; writing the same value here
    // leaves the screen as the model expects whatever the pass does with the register.
    set_text_colour(RESET_COLOR);

    // Directed table. Columns: request, character, index, repeats, typed, then the typed
    // cursor column, cursor row, cell word and scroll flag.
    add_row(REQ_READ, 8'h00, 11'd0, 1, 1, 0, 0, RESET_BLANK, 0);
    add_row(REQ_READ, 8'h00, 11'd1999, 1, 1, 0, 0, RESET_BLANK, 0);
    add_row(REQ_READ, 8'h00, 11'd2000, 1, 1, 0, 0, 16'h0000, 0);
    add_row(REQ_READ, 8'hFF, 11'd2047, 1, 1, 0, 0, 16'h0000, 0);
    add_row(REQ_NONE, 8'hFF, 11'd2047, 1, 1, 0, 0, 16'h0000, 0);
    add_row(REQ_PUT, 8'h41, 11'd0, 1, 1, 1, 0, 16'h0000, 0);
    add_row(REQ_READ, 8'h00, 11'd0, 1, 1, 1, 0, {RESET_COLOR, 8'h41}, 0);
    add_row(REQ_PUT, CH_BACKSPACE, 11'd0, 1, 1, 0, 0, 16'h0000, 0);
    add_row(REQ_READ, 8'h00, 11'd0, 1, 1, 0, 0, RESET_BLANK, 0);
    // Backspace at column zero must not step back onto the row above.
    add_row(REQ_PUT, CH_BACKSPACE, 11'd0, 1, 1, 0, 0, 16'h0000, 0);
    add_row(REQ_PUT, 8'h00, 11'd0, 1, 0, 0, 0, 16'h0000, 0);
    add_row(REQ_PUT, 8'hFF, 11'd2047, 1, 0, 0, 0, 16'h0000, 0);
    add_row(REQ_PUT, CH_RETURN, 11'd0, 1, 1, 0, 0, 16'h0000, 0);
    add_row(REQ_PUT, CH_NEWLINE, 11'd0, 1, 1, 0, 1, 16'h0000, 0);
    add_row(REQ_PUT, CH_NEWLINE, 11'd0, ROWS - 2, 0, 0, 0, 16'h0000, 0);
    // A newline on the bottom row scrolls.
    add_row(REQ_PUT, CH_NEWLINE, 11'd0, 1, 1, 0, ROWS - 1, 16'h0000, 1);
    add_row(REQ_READ, 8'h00, 11'd1920, 1, 0, 0, 0, 16'h0000, 0);
    add_row(REQ_PUT, 8'h5A, 11'd0, COLUMNS - 1, 0, 0, 0, 16'h0000, 0);
    // Filling the last column of the bottom row wraps and scrolls in one go.
    add_row(REQ_PUT, 8'h5A, 11'd0, 1, 1, 0, ROWS - 1, 16'h0000, 1);
    add_row(REQ_READ, 8'h00, 11'd1919, 1, 0, 0, 0, 16'h0000, 0);
    add_row(REQ_CLEAR, 8'hFF, 11'd2047, 1, 1, 0, 0, 16'h0000, 0);
    add_row(REQ_READ, 8'h00, 11'd1999, 1, 1, 0, 0, RESET_BLANK, 0);

    foreach (stimulus_table[i]) begin
      for (k = 0; k < stimulus_table[i].reps; k++) begin
        send_request(stimulus_table[i].req, stimulus_table[i].typed, stimulus_table[i].want);
      end
    end

    // Random phases, each under its own colour, the extreme attributes among them. One phase
    // runs with both sides always willing.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       colour = 8'h00;
        1:       colour = 8'hFF;
        4:       colour = 8'h1E;
        default: colour = COLOR_W'($urandom_range(0, 255));
      endcase
      set_text_colour(colour);
      idle_on = (ph != BURST_PHASE);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_request(draw_request(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests with %0d results: %0d reads, %0d clears, %0d scrolls.",
             requests_sent, results_seen, read_count, clear_count, scroll_count);
    $display("Colour register written %0d times; %0d mismatches.", colour_writes, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
